[rtl/kde_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kde_pkg
// Shared types, constants and helpers of the key debounce event encoder.
// ----------------------------------------------------------------------------
package kde_pkg;

  localparam int KEY_PINS      = 8;
  localparam int SAMPLED_KEYS  = 4;
  localparam int AGREE_SAMPLES = 3;
  localparam int LAMP_W        = 7;
  localparam int SLOT_W        = (AGREE_SAMPLES > 1) ? $clog2(AGREE_SAMPLES) : 1;

  localparam logic [4:0] ID_BASE = 5'd3;
  localparam logic [4:0] ID_NONE = 5'd16;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_PRESS        = 3'd1,
    EV_LONG         = 3'd2,
    EV_REPEAT       = 3'd3,
    EV_RELEASE_LONG = 3'd4,
    EV_SHORT        = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    CFG_FIRST_REPEAT    = 3'd0,
    CFG_REPEAT_INTERVAL = 3'd1,
    CFG_LONG_PRESS      = 3'd2,
    CFG_HOLD            = 3'd3,
    CFG_KEY_ENABLE      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]              first_repeat_ticks;
    logic [7:0]              repeat_interval_ticks;
    logic [7:0]              long_press_ticks;
    logic [7:0]              hold_ticks;
    logic [SAMPLED_KEYS-1:0] key_enable_mask;
  } cfg_t;

  // result of judging a sample group
  typedef struct packed {
    logic       hit;
    logic [2:0] key;
  } confirm_t;

  function automatic logic [7:0] reload(input logic [7:0] v);
    reload = (v == 8'hff) ? 8'hff : v + 8'd1;
  endfunction

endpackage
`default_nettype wire

[rtl/kde_sampler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kde_sampler
// Stores press samples and judges each completed group for a stable press.
// ----------------------------------------------------------------------------
module kde_sampler import kde_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  logic [SAMPLED_KEYS-1:0] sample_i,
  output confirm_t                confirm_o
);

  logic [SAMPLED_KEYS-1:0] store_q [AGREE_SAMPLES];
  logic [SLOT_W-1:0]       slot_q, slot_d, slot_eff;
  logic                    last_slot;
  logic                    same;

  always_comb begin
    slot_eff  = (int'(slot_q) >= AGREE_SAMPLES) ? '0 : slot_q;
    last_slot = (int'(slot_eff) == AGREE_SAMPLES - 1);
    slot_d    = last_slot ? '0 : slot_eff + SLOT_W'(1);
  end

  // current sample stands in for the last entry of the group
  always_comb begin
    same = (sample_i != '0);
    for (int i = 0; i < AGREE_SAMPLES - 1; i++) begin
      if (store_q[i] != sample_i) same = 1'b0;
    end
    confirm_o.hit = last_slot && same;
    confirm_o.key = '0;
    for (int i = SAMPLED_KEYS - 1; i >= 0; i--) begin
      if (sample_i[i]) confirm_o.key = 3'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (advance_i) begin
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      store_q[slot_eff] <= sample_i;
    end
  end

endmodule
`default_nettype wire

[rtl/kde_encoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kde_encoder
// Press state, hold/repeat/long timers and event selection per tick.
// ----------------------------------------------------------------------------
module kde_encoder import kde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  cfg_t       cfg_i,
  input  confirm_t   confirm_i,
  output event_e     event_o,
  output logic [4:0] key_id_o
);

  logic [7:0] hold_q, hold_d;
  logic [7:0] rep_q, rep_d;
  logic [7:0] long_q, long_d;
  logic       valid_q, valid_d;
  logic       seen_q, seen_d;
  logic [2:0] key_q, key_d;
  event_e     ev_d, ev_q;
  logic [4:0] id_d, id_q;

  always_comb begin
    rep_d   = (rep_q > 8'd1) ? rep_q - 8'd1 : rep_q;
    long_d  = (long_q > 8'd1) ? long_q - 8'd1 : long_q;
    hold_d  = (hold_q != 8'hff) ? hold_q + 8'd1 : hold_q;
    valid_d = valid_q && (hold_d < cfg_i.hold_ticks);
    seen_d  = seen_q;
    key_d   = key_q;
    ev_d    = EV_NONE;

    if (confirm_i.hit) begin
      valid_d = 1'b1;
      hold_d  = '0;
      key_d   = confirm_i.key;
    end

    if (valid_d) begin
      if (!seen_q) begin
        seen_d = 1'b1;
        rep_d  = reload(cfg_i.first_repeat_ticks);
        long_d = reload(cfg_i.long_press_ticks);
        ev_d   = EV_PRESS;
      end else if (long_d == 8'd1) begin
        long_d = '0;
        ev_d   = EV_LONG;
      end else if (rep_d == 8'd1) begin
        rep_d = reload(cfg_i.repeat_interval_ticks);
        ev_d  = EV_REPEAT;
      end
    end else if (seen_q) begin
      seen_d = 1'b0;
      ev_d   = (long_d == 8'd0) ? EV_RELEASE_LONG : EV_SHORT;
    end

    id_d = (ev_d != EV_NONE) ? ID_BASE + {2'b00, key_d} : ID_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= '0;
      rep_q   <= '0;
      long_q  <= '0;
      valid_q <= 1'b0;
      seen_q  <= 1'b0;
      key_q   <= '0;
    end else if (advance_i) begin
      hold_q  <= hold_d;
      rep_q   <= rep_d;
      long_q  <= long_d;
      valid_q <= valid_d;
      seen_q  <= seen_d;
      key_q   <= key_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      ev_q <= ev_d;
      id_q <= id_d;
    end
  end

  assign event_o  = ev_q;
  assign key_id_o = id_q;

endmodule
`default_nettype wire

[rtl/key_debounce_event_encoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_debounce_event_encoder_unit
// Key debounce with press, long-press, auto-repeat and release events.
// ----------------------------------------------------------------------------
// throughput: one tick per cycle unless out_ready_i stalls the result, set by
// the input register and result register pair; the input register takes one
// more tick while a result waits
// reset: asynchronous, clears timers, press flags, group slot and handshake state;
// config registers return to their defaults, sample entries are left as they are
module key_debounce_event_encoder_unit import kde_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KEY_PINS-1:0] key_levels_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          event_res_o,
  output logic [4:0]          key_id_o,
  output logic [LAMP_W-1:0]   lamp_drive_o
);

  cfg_t                    cfg_q;
  logic                    in_valid_q;
  logic [KEY_PINS-1:0]     levels_q;
  logic                    out_valid_q;
  logic [LAMP_W-1:0]       lamp_q;
  logic                    advance;
  logic [KEY_PINS-1:0]     low;
  logic [SAMPLED_KEYS-1:0] sample;
  confirm_t                confirm;
  event_e                  ev;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign low    = ~levels_q;
  assign sample = low[SAMPLED_KEYS-1:0] & cfg_q.key_enable_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_repeat_ticks    <= 8'd50;
      cfg_q.repeat_interval_ticks <= 8'd15;
      cfg_q.long_press_ticks      <= 8'd120;
      cfg_q.hold_ticks            <= 8'd7;
      cfg_q.key_enable_mask       <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_REPEAT:    cfg_q.first_repeat_ticks    <= cfg_wdata_i;
        CFG_REPEAT_INTERVAL: cfg_q.repeat_interval_ticks <= cfg_wdata_i;
        CFG_LONG_PRESS:      cfg_q.long_press_ticks      <= cfg_wdata_i;
        CFG_HOLD:            cfg_q.hold_ticks            <= cfg_wdata_i;
        CFG_KEY_ENABLE:      cfg_q.key_enable_mask <= cfg_wdata_i[SAMPLED_KEYS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) levels_q <= key_levels_i;
    if (advance) lamp_q <= low[LAMP_W:1];
  end

  kde_sampler u_sampler (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .sample_i  (sample),
    .confirm_o (confirm)
  );

  kde_encoder u_encoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cfg_i     (cfg_q),
    .confirm_i (confirm),
    .event_o   (ev),
    .key_id_o  (key_id_o)
  );

  assign out_valid_o  = out_valid_q;
  assign event_res_o  = ev;
  assign lamp_drive_o = lamp_q;

endmodule
`default_nettype wire

[rtl/kde_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kde_checker
// Port-level checks of the key debounce event encoder, bound to the top.
// ----------------------------------------------------------------------------
module kde_checker import kde_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [2:0]          event_res_o,
  input logic [4:0]          key_id_o,
  input logic [LAMP_W-1:0]   lamp_drive_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_res_o)
      && $stable(key_id_o) && $stable(lamp_drive_o))
    else $error("result changed while stalled");

  // input side never blocks while the result slot is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request blocked with empty result slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((event_res_o == EV_NONE) == (key_id_o == ID_NONE)))
    else $error("key id does not match event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (key_id_o != ID_NONE) |->
      (key_id_o >= ID_BASE) && (key_id_o < ID_BASE + 5'(SAMPLED_KEYS)))
    else $error("key id out of sampled range");

endmodule

bind key_debounce_event_encoder_unit kde_checker u_kde_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .event_res_o  (event_res_o),
  .key_id_o     (key_id_o),
  .lamp_drive_o (lamp_drive_o)
);
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the key debounce event encoder against a cycle-free predictor of its
// tick behavior: directed key sequences, then held and bouncing key patterns
// under several register settings and handshake pacing modes.
// ----------------------------------------------------------------------------
module tb;
  import kde_pkg::*;

  localparam int LIMIT = 200000;

  typedef struct {
    event_e      ev;
    logic [4:0]  id;
    logic [6:0]  lamps;
  } key_event_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = 3'd0;
  logic [7:0] cfg_wdata_i = 8'd0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] key_levels_i = 8'hff;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] event_res_o;
  logic [4:0] key_id_o;
  logic [6:0] lamp_drive_o;

  key_debounce_event_encoder_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .key_levels_i (key_levels_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_res_o  (event_res_o),
    .key_id_o     (key_id_o),
    .lamp_drive_o (lamp_drive_o)
  );

  always #4 clk_i = ~clk_i;

  // predictor state and its copy of the registers
  cfg_t       key_cfg;
  logic [3:0] group_smp [AGREE_SAMPLES];
  int         group_slot;
  logic       press_active;
  logic       press_reported;
  logic [2:0] held_key;
  logic [7:0] hold_cnt;
  logic [7:0] repeat_cnt;
  logic [7:0] long_cnt;

  key_event_t pending_events[$];
  int         src_idle_pct = 21;
  int         rcv_idle_pct = 70;
  int         ticks_sent = 0;
  int         ticks_checked = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  int         event_seen [8];

  function automatic logic [7:0] reload_sat(input logic [7:0] v);
    return (v == 8'hff) ? 8'hff : v + 8'd1;
  endfunction

  function automatic void predict_tick(input logic [7:0] levels, output key_event_t r);
    logic [7:0] low;
    logic [3:0] smp;
    logic       agree;
    logic       found;
    low = ~levels;
    smp = low[3:0] & key_cfg.key_enable_mask;
    r.ev = EV_NONE;
    r.id = ID_NONE;
    r.lamps = low[7:1];

    if (repeat_cnt > 8'd1) repeat_cnt--;
    if (long_cnt > 8'd1) long_cnt--;
    if (hold_cnt != 8'hff) hold_cnt++;
    if (hold_cnt >= key_cfg.hold_ticks) press_active = 1'b0;

    if (group_slot >= AGREE_SAMPLES) group_slot = 0;
    group_smp[group_slot] = smp;
    group_slot++;
    if (group_slot >= AGREE_SAMPLES) begin
      group_slot = 0;
      agree = (group_smp[0] != 4'd0);
      for (int i = 1; i < AGREE_SAMPLES; i++)
        if (group_smp[i] != group_smp[0]) agree = 1'b0;
      found = 1'b0;
      // lowest pressed key wins
      for (int k = 0; k < SAMPLED_KEYS; k++) begin
        if (agree && !found && group_smp[0][k]) begin
          found = 1'b1;
          press_active = 1'b1;
          hold_cnt = 8'd0;
          held_key = k[2:0];
        end
      end
    end

    if (press_active) begin
      if (!press_reported) begin
        press_reported = 1'b1;
        repeat_cnt = reload_sat(key_cfg.first_repeat_ticks);
        long_cnt = reload_sat(key_cfg.long_press_ticks);
        r.ev = EV_PRESS;
      end else if (long_cnt == 8'd1) begin
        // long wins when both timers run out together
        long_cnt = 8'd0;
        r.ev = EV_LONG;
      end else if (repeat_cnt == 8'd1) begin
        repeat_cnt = reload_sat(key_cfg.repeat_interval_ticks);
        r.ev = EV_REPEAT;
      end
    end else if (press_reported) begin
      press_reported = 1'b0;
      r.ev = (long_cnt == 8'd0) ? EV_RELEASE_LONG : EV_SHORT;
    end
    if (r.ev != EV_NONE) r.id = ID_BASE + {2'b00, held_key};
  endfunction

  // entered and left at a falling edge
  task automatic send_tick(input logic [7:0] levels);
    key_event_t r;
    int gap;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_levels_i <= levels;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_tick(levels, r);
    pending_events.push_back(r);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_config(input cfg_t c);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_FIRST_REPEAT;
    cfg_wdata_i <= c.first_repeat_ticks;
    @(negedge clk_i);
    cfg_idx_i <= CFG_REPEAT_INTERVAL;
    cfg_wdata_i <= c.repeat_interval_ticks;
    @(negedge clk_i);
    cfg_idx_i <= CFG_LONG_PRESS;
    cfg_wdata_i <= c.long_press_ticks;
    @(negedge clk_i);
    cfg_idx_i <= CFG_HOLD;
    cfg_wdata_i <= c.hold_ticks;
    @(negedge clk_i);
    cfg_idx_i <= CFG_KEY_ENABLE;
    cfg_wdata_i <= {4'h0, c.key_enable_mask};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    key_cfg = c;
  endtask

  function automatic logic [7:0] pins_with(input logic [3:0] pressed);
    return (8'($urandom()) & 8'hf0) | {4'h0, ~pressed};
  endfunction

  // mostly held keys with random content, some bounce, noise and key changes
  task automatic run_keys(input int n, input int max_hold, input int max_gap);
    int start;
    int len;
    int kind;
    logic [3:0] pressed;
    logic paused;
    start = ticks_sent;
    paused = 1'b0;
    while (ticks_sent - start < n) begin
      if (!paused && ticks_sent - start >= n / 2) begin
        settle();
        paused = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 15) begin
        len = $urandom_range(1, 6);
        repeat (len) send_tick(8'($urandom()));
      end else begin
        pressed = 4'($urandom_range(1, 15));
        // contact bounce before the key settles
        if (kind < 40) repeat ($urandom_range(1, 2)) send_tick(8'($urandom()));
        len = $urandom_range(3, max_hold);
        repeat (len) send_tick(pins_with(pressed));
        if (kind < 85) begin
          len = $urandom_range(1, max_gap);
          repeat (len) send_tick(pins_with(4'h0));
        end
      end
    end
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.first_repeat_ticks = 8'($urandom_range(1, 40));
    c.repeat_interval_ticks = 8'($urandom_range(1, 20));
    c.long_press_ticks = 8'($urandom_range(1, 60));
    c.hold_ticks = 8'($urandom_range(1, 12));
    c.key_enable_mask = 4'($urandom_range(0, 15));
    return c;
  endfunction

  task automatic test_directed();
    cfg_t c;
    c = '{8'd5, 8'd1, 8'd5, 8'd4, 4'hf};
    set_config(c);
    send_tick(8'hff);
    repeat (5) send_tick(8'h00);
    // key 0 held: long and repeat timers run out on the same tick
    repeat (12) send_tick(8'h5e);
    repeat (5) send_tick(8'hff);
    // keys 2 and 3 together latch key 2, then a short release
    repeat (5) send_tick(8'ha3);
    repeat (4) send_tick(8'hff);
  endtask

  task automatic test_default_timing();
    settle();
    set_config('{8'd50, 8'd15, 8'd120, 8'd7, 4'hf});
    run_keys(60, 140, 12);
  endtask

  task automatic test_fast_timing();
    settle();
    set_config('{8'd1, 8'd1, 8'd1, 8'd1, 4'h1});
    run_keys(60, 12, 6);
  endtask

  task automatic test_random_timing();
    repeat (2) begin
      settle();
      set_config(random_cfg());
      run_keys(60, 40, 10);
    end
  endtask

  task automatic test_key_mask();
    settle();
    set_config('{8'd3, 8'd2, 8'd8, 8'd5, 4'h0});
    run_keys(40, 12, 6);
    settle();
    set_config('{8'd3, 8'd2, 8'd8, 8'd5, 4'h8});
    run_keys(40, 12, 6);
  endtask

  task automatic test_slow_timing();
    settle();
    set_config('{8'd254, 8'd254, 8'd254, 8'd255, 4'hf});
    // past long press and first repeat, then let the hold counter saturate
    repeat (262) send_tick(pins_with(4'h2));
    repeat (258) send_tick(pins_with(4'h0));
    run_keys(30, 20, 8);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    key_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: result with no request pending: event %0d key %0d lamps %h",
                   event_res_o, key_id_o, lamp_drive_o);
      end else begin
        want = pending_events.pop_front();
        ticks_checked++;
        event_seen[want.ev]++;
        if (event_res_o !== want.ev || key_id_o !== want.id || lamp_drive_o !== want.lamps)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: tick %0d expected event %0d key %0d lamps %h, got %0d %0d %h",
                     ticks_checked, want.ev, want.id, want.lamps,
                     event_res_o, key_id_o, lamp_drive_o);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    key_cfg = '{8'd50, 8'd15, 8'd120, 8'd7, 4'hf};
    group_slot = 0;
    press_active = 1'b0;
    press_reported = 1'b0;
    held_key = 3'd0;
    hold_cnt = 8'd0;
    repeat_cnt = 8'd0;
    long_cnt = 8'd0;
    foreach (group_smp[i]) group_smp[i] = 4'd0;
    foreach (event_seen[i]) event_seen[i] = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_default_timing();
    test_fast_timing();
    src_idle_pct = 70;
    rcv_idle_pct = 21;
    test_random_timing();
    test_key_mask();
    src_idle_pct = 0;
    rcv_idle_pct = 0;
    test_slow_timing();

    settle();
    repeat (4) @(negedge clk_i);
    $display("tb: %0d ticks checked under three pacing modes and eight register settings",
             ticks_checked);
    $display("tb: events seen: %0d press, %0d long, %0d repeat, %0d long release, %0d short",
             event_seen[EV_PRESS], event_seen[EV_LONG], event_seen[EV_REPEAT],
             event_seen[EV_RELEASE_LONG], event_seen[EV_SHORT]);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
